/* rtl/core/bthal_pkg.sv */
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator package
// Heap geometry, header bit positions, status codes and the power-up image of
// the heap store.
// ----------------------------------------------------------------------------
`default_nettype none

package bthal_pkg;

  localparam int HEAP_WORDS    = 4096;
  localparam int HEAP_AW       = $clog2(HEAP_WORDS);
  localparam int HEAP_NW       = HEAP_AW + 1;
  localparam int HEAP_CAP      = 4 * HEAP_WORDS;
  localparam int CHUNK_RESET   = 4096;
  localparam int FIRST_PAYLOAD = 8;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] BIT_ALLOC = 32'h0000_0001;
  localparam logic [31:0] BIT_PREV  = 32'h0000_0002;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_NULL = 2'd2;

  // Configuration register byte address
  localparam logic [1:0] REG_CHUNK = 2'd0;

  // Initial chunk fits when the first growth stays strictly below the cap.
  localparam bit INIT_FITS  = (CHUNK_RESET < HEAP_CAP - 16);
  localparam int INIT_BRK   = INIT_FITS ? (16 + CHUNK_RESET) : 16;
  localparam int INIT_FTR_W = (16 + CHUNK_RESET - 8) / 4;
  localparam int INIT_EPI_W = INIT_FTR_W + 1;

  typedef logic [HEAP_AW-1:0] heap_idx_t;

  // Power-up contents: prologue, one free chunk, epilogue.
  function automatic logic [31:0] init_word(input heap_idx_t idx);
    logic [31:0] w;
    w = '0;
    if (idx == HEAP_AW'(1) || idx == HEAP_AW'(2)) begin
      w = 32'd8 | BIT_ALLOC | BIT_PREV;
    end else if (idx == HEAP_AW'(3)) begin
      w = INIT_FITS ? (32'(CHUNK_RESET) | BIT_PREV) : (BIT_ALLOC | BIT_PREV);
    end else if (INIT_FITS && idx == HEAP_AW'(INIT_FTR_W)) begin
      w = 32'(CHUNK_RESET);
    end else if (INIT_FITS && idx == HEAP_AW'(INIT_EPI_W)) begin
      w = BIT_ALLOC;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bthal_if.sv */
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bthal_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [13:0] req_size;
  logic [13:0] block_addr;
  modport source (output valid, req_type, req_size, block_addr, input ready);
  modport sink   (input valid, req_type, req_size, block_addr, output ready);
endinterface

interface bthal_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [13:0] payload_addr;
  modport source (output valid, status, payload_addr, input ready);
  modport sink   (input valid, status, payload_addr, output ready);
endinterface

`default_nettype wire

/* rtl/core/boundary_tag_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator
// Next-fit implicit free list allocator over a word heap store.
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time; the header walk over the single heap
//   memory port sets the pace.
// Reset: synchronous; a pass over every heap word then writes the power-up
//   image of the heap store, and no request transaction is taken until it ends.
`default_nettype none

module boundary_tag_heap_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  bthal_req_if.sink        req,
  bthal_rsp_if.source      rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import bthal_pkg::*;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DEC,
    S_F_RA, S_F_RD, S_F_NB, S_F_WF, S_F_RN, S_F_WN,
    S_M_R0, S_M_D0, S_M_R1, S_M_D1, S_M_D2,
    S_MA1, S_MA2, S_MA3, S_MA4,
    S_MB0, S_MB1, S_MB2, S_MB3, S_MB4, S_MB5,
    S_MC0, S_MC1,
    S_P1_RA, S_P1_EV, S_P1_END, S_P2_RA, S_P2_EV,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5,
    S_T_RA, S_T_D, S_T_S1, S_T_S2, S_T_S3, S_T_S4, S_T_S5, S_T_S6, S_T_S7,
    S_T_N1, S_T_N2, S_T_N3, S_T_N4, S_T_N5,
    S_DONE
  } state_t;

  state_t state;

  // Configuration register
  logic [14:0] chunk;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_CHUNK) ? {17'd0, chunk} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= 15'(CHUNK_RESET);
    end else if (psel && penable && pwrite) begin
      chunk <= pwdata[14:0];
    end
  end

  // Allocator state
  logic [31:0]        cursor, old, bp, nb, pb, size, own, nsize, res;
  logic [14:0]        brk, need;
  logic [15:0]        gbytes;
  logic [HEAP_NW-1:0] n;
  logic [HEAP_AW-1:0] clr_cnt;
  logic               kind_q, pre, ppre, prev_a, next_a, ret_grow;
  logic [13:0]        size_q, addr_q;
  logic [1:0]         stat;
  logic               rsp_valid;
  logic [1:0]         rsp_status;
  logic [13:0]        rsp_addr;

  // Shared 32-bit address/size adder
  logic [31:0] add_a, add_b, add_sum;
  logic        add_sub;
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};

  // Heap memory port
  logic               mem_we, wr_en, in_store, rd_oor;
  logic [HEAP_AW-1:0] mem_addr;
  logic [31:0]        mem_wdata, wdata, ram_rdata, rdv, rsz;

  assign in_store = (add_sum[31:HEAP_AW+2] == '0);
  assign rdv      = rd_oor ? 32'd0 : ram_rdata;
  assign rsz      = rdv & SIZE_MASK;

  always_comb begin
    if (state == S_CLR) begin
      mem_addr  = clr_cnt;
      mem_we    = 1'b1;
      mem_wdata = init_word(clr_cnt);
    end else begin
      mem_addr  = add_sum[HEAP_AW+1:2];
      mem_we    = wr_en && in_store;
      mem_wdata = wdata;
    end
  end

  bthal_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (ram_rdata)
  );

  // Growth size: larger of chunk and need, in words rounded to even count
  logic [14:0] ext;
  logic [12:0] ext_w;
  logic [15:0] grow_bytes;
  assign ext        = (chunk > need) ? chunk : need;
  assign ext_w      = ext[14:2];
  assign grow_bytes = {(14'(ext_w) + 14'(ext_w[0])), 2'b00};

  // Next-fit candidate test
  logic fits;
  assign fits = !rdv[0] && ({17'd0, need} <= rsz);

  logic [14:0] need_calc;
  assign need_calc = (size_q <= 14'd8) ? 15'd16
                   : ((15'(size_q) + 15'd15) & 15'h7FF8);

  // Per-step operands of the adder and heap writes
  always_comb begin
    add_a   = bp;
    add_b   = 32'd4;
    add_sub = 1'b1;
    wr_en   = 1'b0;
    wdata   = '0;
    case (state)
      S_F_RD: begin
        wr_en = 1'b1;
        wdata = rdv & ~(32'd7 & ~BIT_PREV);
      end
      S_F_NB: begin add_b = size; add_sub = 1'b0; end
      S_F_WF: begin add_a = nb; add_b = 32'd8; wr_en = 1'b1; wdata = size; end
      S_F_RN: add_a = nb;
      S_F_WN: begin add_a = nb; wr_en = 1'b1; wdata = rdv & ~BIT_PREV; end
      S_M_D0: begin add_b = rsz; add_sub = 1'b0; end
      S_M_R1: add_a = nb;
      S_M_D1: add_b = 32'd8;
      S_M_D2: add_b = rsz;
      S_MA1:  begin add_a = size; add_b = nsize; add_sub = 1'b0; end
      S_MA2:  begin wr_en = 1'b1; wdata = size | BIT_PREV; end
      S_MA3:  begin add_b = size; add_sub = 1'b0; end
      S_MA4:  begin add_a = nb; add_b = 32'd8; wr_en = 1'b1; wdata = size; end
      S_MB0:  add_a = pb;
      S_MB1:  begin add_a = size; add_b = rsz; add_sub = 1'b0; end
      S_MB2:  begin add_a = size; add_b = nsize; add_sub = 1'b0; end
      S_MB3: begin
        add_a = pb;
        wr_en = 1'b1;
        wdata = size | (ppre ? BIT_PREV : 32'd0);
      end
      S_MB4: begin
        add_a   = next_a ? bp : nb;
        add_b   = next_a ? own : nsize;
        add_sub = 1'b0;
      end
      S_MB5:  begin add_a = nb; add_b = 32'd8; wr_en = 1'b1; wdata = size; end
      S_MC1:  begin add_b = rsz; add_sub = 1'b0; end
      S_P1_RA, S_P2_RA: add_a = cursor;
      S_P1_EV, S_P2_EV: begin add_a = cursor; add_b = rsz; add_sub = 1'b0; end
      S_G0: begin
        add_a   = {17'd0, brk};
        add_b   = {16'd0, grow_bytes};
        add_sub = 1'b0;
      end
      S_G2: begin
        wr_en = 1'b1;
        wdata = {16'd0, gbytes} | (rdv & BIT_PREV);
      end
      S_G3: begin add_b = {16'd0, gbytes}; add_sub = 1'b0; end
      S_G4: begin add_a = nb; add_b = 32'd8; wr_en = 1'b1; wdata = {16'd0, gbytes}; end
      S_G5: begin add_a = nb; wr_en = 1'b1; wdata = BIT_ALLOC; end
      S_T_D:  begin add_a = {17'd0, need}; add_b = 32'd8; add_sub = 1'b0; end
      S_T_S1: begin add_a = size; add_b = {17'd0, need}; end
      S_T_S2: begin
        wr_en = 1'b1;
        wdata = {17'd0, need} | BIT_ALLOC | (pre ? BIT_PREV : 32'd0);
      end
      S_T_S3: begin add_b = {17'd0, need}; add_sub = 1'b0; end
      S_T_S4: begin
        add_a = nb;
        add_b = 32'd8;
        wr_en = 1'b1;
        wdata = {17'd0, need} | BIT_ALLOC;
      end
      S_T_S5: begin add_a = nb; wr_en = 1'b1; wdata = size | BIT_PREV; end
      S_T_S6: begin add_a = nb; add_b = size; add_sub = 1'b0; end
      S_T_S7: begin add_a = nb; add_b = 32'd8; wr_en = 1'b1; wdata = size; end
      S_T_N1: begin
        wr_en = 1'b1;
        wdata = size | BIT_ALLOC | (pre ? BIT_PREV : 32'd0);
      end
      S_T_N2: begin add_b = size; add_sub = 1'b0; end
      S_T_N3: begin add_a = nb; add_b = 32'd8; wr_en = 1'b1; wdata = size | BIT_ALLOC; end
      S_T_N4: add_a = nb;
      S_T_N5: begin add_a = nb; wr_en = 1'b1; wdata = rdv | BIT_PREV; end
      default: ;
    endcase
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.payload_addr = rsp_addr;

  // Sequencer
  always_ff @(posedge clk) begin
    rd_oor <= !in_store;
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      cursor    <= 32'(FIRST_PAYLOAD);
      brk       <= 15'(INIT_BRK);
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response once taken; the finishing step reloads it itself
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            kind_q <= req.req_type;
            size_q <= req.req_size;
            addr_q <= req.block_addr;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          stat <= STAT_DONE;
          if (!kind_q) begin
            need <= need_calc;
            old  <= cursor;
            n    <= '0;
            if (size_q == '0) begin
              stat  <= STAT_NULL;
              state <= S_DONE;
            end else begin
              state <= S_P1_RA;
            end
          end else begin
            bp <= {18'd0, addr_q[13:2], 2'b00};
            if (addr_q == '0) begin
              stat  <= STAT_NULL;
              state <= S_DONE;
            end else begin
              state <= S_F_RA;
            end
          end
        end
        // Free: clear allocated bits, update successor
        S_F_RA: state <= S_F_RD;
        S_F_RD: begin size <= rsz; state <= S_F_NB; end
        S_F_NB: begin nb <= add_sum; state <= S_F_WF; end
        S_F_WF: state <= S_F_RN;
        S_F_RN: state <= S_F_WN;
        S_F_WN: begin ret_grow <= 1'b0; state <= S_M_R0; end
        // Merge with free neighbors
        S_M_R0: state <= S_M_D0;
        S_M_D0: begin
          size   <= rsz;
          prev_a <= rdv[1];
          nb     <= add_sum;
          state  <= S_M_R1;
        end
        S_M_R1: state <= S_M_D1;
        S_M_D1: begin
          next_a <= rdv[0];
          nsize  <= rsz;
          state  <= S_M_D2;
        end
        S_M_D2: begin
          pb <= add_sum;
          if (prev_a && next_a) begin
            if (ret_grow) begin
              state <= S_T_RA;
            end else begin
              res   <= bp;
              state <= S_DONE;
            end
          end else if (prev_a) begin
            state <= S_MA1;
          end else begin
            state <= S_MB0;
          end
        end
        S_MA1: begin size <= add_sum; state <= S_MA2; end
        S_MA2: state <= S_MA3;
        S_MA3: begin nb <= add_sum; state <= S_MA4; end
        S_MA4: state <= S_MC0;
        S_MB0: state <= S_MB1;
        S_MB1: begin
          own   <= size;
          size  <= add_sum;
          ppre  <= rdv[1];
          state <= next_a ? S_MB3 : S_MB2;
        end
        S_MB2: begin size <= add_sum; state <= S_MB3; end
        S_MB3: state <= S_MB4;
        S_MB4: begin nb <= add_sum; state <= S_MB5; end
        S_MB5: begin bp <= pb; state <= S_MC0; end
        S_MC0: state <= S_MC1;
        S_MC1: begin
          // Pull the cursor back when it now points inside the merged block
          if (cursor > bp && cursor < add_sum) begin
            cursor <= bp;
          end
          if (ret_grow) begin
            state <= S_T_RA;
          end else begin
            res   <= bp;
            state <= S_DONE;
          end
        end
        // Next-fit search from cursor to epilogue
        S_P1_RA: state <= (n == HEAP_NW'(HEAP_WORDS)) ? S_P1_END : S_P1_EV;
        S_P1_EV: begin
          if (rsz == '0) begin
            state <= S_P1_END;
          end else if (fits) begin
            bp    <= cursor;
            state <= S_T_RA;
          end else begin
            cursor <= add_sum;
            n      <= n + 1'b1;
            state  <= S_P1_RA;
          end
        end
        S_P1_END: begin
          cursor <= 32'(FIRST_PAYLOAD);
          n      <= '0;
          state  <= S_P2_RA;
        end
        // Wrapped pass from the first block up to the old cursor
        S_P2_RA: begin
          if (n == HEAP_NW'(HEAP_WORDS) || !(cursor < old)) begin
            state <= S_G0;
          end else begin
            state <= S_P2_EV;
          end
        end
        S_P2_EV: begin
          if (fits) begin
            bp    <= cursor;
            state <= S_T_RA;
          end else begin
            cursor <= add_sum;
            n      <= n + 1'b1;
            state  <= S_P2_RA;
          end
        end
        // Grow the break
        S_G0: begin
          if (grow_bytes == '0 || {17'd0, brk} >= 32'(HEAP_CAP)
              || add_sum >= 32'(HEAP_CAP)) begin
            stat  <= STAT_OOM;
            state <= S_DONE;
          end else begin
            brk    <= add_sum[14:0];
            bp     <= {17'd0, brk};
            gbytes <= grow_bytes;
            state  <= S_G1;
          end
        end
        S_G1: state <= S_G2;
        S_G2: state <= S_G3;
        S_G3: begin nb <= add_sum; state <= S_G4; end
        S_G4: state <= S_G5;
        S_G5: begin ret_grow <= 1'b1; state <= S_M_R0; end
        // Place the block, splitting off the remainder when large enough
        S_T_RA: state <= S_T_D;
        S_T_D: begin
          size  <= rsz;
          pre   <= rdv[1];
          state <= (rsz >= add_sum) ? S_T_S1 : S_T_N1;
        end
        S_T_S1: begin size <= add_sum; state <= S_T_S2; end
        S_T_S2: state <= S_T_S3;
        S_T_S3: begin nb <= add_sum; state <= S_T_S4; end
        S_T_S4: state <= S_T_S5;
        S_T_S5: state <= S_T_S6;
        S_T_S6: begin nb <= add_sum; state <= S_T_S7; end
        S_T_S7: begin res <= bp; state <= S_DONE; end
        S_T_N1: state <= S_T_N2;
        S_T_N2: begin nb <= add_sum; state <= S_T_N3; end
        S_T_N3: state <= S_T_N4;
        S_T_N4: state <= S_T_N5;
        S_T_N5: begin res <= bp; state <= S_DONE; end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= stat;
            rsp_addr   <= (stat == STAT_DONE) ? res[13:0] : 14'd0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bthal_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bthal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/core/bthal_checker.sv */
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bthal_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic [13:0] payload_addr
);
  import bthal_pkg::*;

  // Clearing pass follows reset: no request is taken
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready right after reset");

  // One transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request ready right after accept");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == STAT_DONE || status == STAT_OOM || status == STAT_NULL))
    else $error("undefined status");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_DONE |-> payload_addr == 14'd0)
    else $error("address on failed response");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_addr))
    else $error("stalled response changed");

endmodule

bind boundary_tag_heap_allocator_unit bthal_checker u_bthal_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .payload_addr (rsp.payload_addr)
);

`default_nettype wire

/* sim/boundary_tag_heap_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator testbench
// Drives allocate and free transactions with random sizes and live addresses,
// keeps its own copy of the heap image, cursor and break, and checks every
// response against it. Sweeps the growth chunk and several idle patterns.
// ----------------------------------------------------------------------------

module boundary_tag_heap_allocator_unit_tb;
  import bthal_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int STALL_LIMIT = 60000;
  localparam int HOLD_CYCLES = 800;

  typedef struct packed {
    logic        kind;
    logic [13:0] size;
    logic [13:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] addr;
  } heap_rsp_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bthal_req_if req_ch ();
  bthal_rsp_if rsp_ch ();

  boundary_tag_heap_allocator_unit dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Pending requests, responses planned for them, and responses now owed.
  heap_req_t   pending_reqs[$];
  heap_rsp_t   planned_rsps[$];
  heap_rsp_t   owed_rsps[$];
  int unsigned live_blocks[$];

  int  err_cnt;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_asks;
  int  hold_seen;
  int  hold_left;
  int  quiet_cycles;
  logic req_fire;

  // Shadow heap: word image, break, next-fit cursor and growth chunk.
  logic [31:0] heap_img[HEAP_WORDS];
  int unsigned brk_sh;
  int unsigned cursor_sh;
  int unsigned chunk_sh;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Heap shadow
  // --------------------------------------------------------------------------
  function automatic int unsigned hrd(input int unsigned a);
    int unsigned w;
    w = a >> 2;
    if (w < HEAP_WORDS) return heap_img[w];
    return 0;
  endfunction

  function automatic void hwr(input int unsigned a, input int unsigned v);
    int unsigned w;
    w = a >> 2;
    if (w < HEAP_WORDS) heap_img[w] = v;
  endfunction

  function automatic int unsigned hsz(input int unsigned a);
    return hrd(a) & SIZE_MASK;
  endfunction

  // Merge a freed block with free neighbors; returns the merged payload.
  function automatic int unsigned coalesce(input int unsigned bp_in);
    int unsigned bp, size, pa, nb, na, pb, ppre, own, nsize;
    bp = bp_in;
    size = hsz(bp - 4);
    pa = hrd(bp - 4) & BIT_PREV;
    nb = bp + size;
    na = hrd(nb - 4) & BIT_ALLOC;
    pb = bp - hsz(bp - 8);
    if (pa != 0 && na != 0) return bp;
    if (pa != 0) begin
      size += hsz(nb - 4);
      hwr(bp - 4, size | BIT_PREV);
      hwr(bp + size - 8, size);
    end else if (na != 0) begin
      ppre = hrd(pb - 4) & BIT_PREV;
      own = size;
      size += hsz(pb - 4);
      hwr(pb - 4, size | ppre);
      hwr(bp + own - 8, size);
      bp = pb;
    end else begin
      ppre = hrd(pb - 4) & BIT_PREV;
      nsize = hsz(nb - 4);
      size += hsz(pb - 4) + nsize;
      hwr(pb - 4, size | ppre);
      hwr(nb + nsize - 8, size);
      bp = pb;
    end
    if (cursor_sh > bp && cursor_sh < bp + hsz(bp - 4)) cursor_sh = bp;
    return bp;
  endfunction

  function automatic bit extend_heap(input int unsigned bytes, output int unsigned bp_out);
    int unsigned cap, bp;
    cap = HEAP_CAP;
    bp = brk_sh;
    bp_out = 0;
    if (bytes == 0 || bp >= cap || bytes >= cap - bp) return 1'b0;
    brk_sh = bp + bytes;
    hwr(bp - 4, bytes | (hrd(bp - 4) & BIT_PREV));
    hwr(bp + bytes - 8, bytes);
    hwr(bp + bytes - 4, BIT_ALLOC);
    bp_out = coalesce(bp);
    return 1'b1;
  endfunction

  // Next-fit: cursor to epilogue, then first block up to the old cursor.
  function automatic bit next_fit(input int unsigned need, output int unsigned bp_out);
    int unsigned old, h;
    old = cursor_sh;
    bp_out = 0;
    for (int n = 0; n < HEAP_WORDS && hsz(cursor_sh - 4) > 0; n++) begin
      h = hrd(cursor_sh - 4);
      if ((h & BIT_ALLOC) == 0 && need <= (h & SIZE_MASK)) begin
        bp_out = cursor_sh;
        return 1'b1;
      end
      cursor_sh += h & SIZE_MASK;
    end
    cursor_sh = FIRST_PAYLOAD;
    for (int n = 0; n < HEAP_WORDS && cursor_sh < old; n++) begin
      h = hrd(cursor_sh - 4);
      if ((h & BIT_ALLOC) == 0 && need <= (h & SIZE_MASK)) begin
        bp_out = cursor_sh;
        return 1'b1;
      end
      cursor_sh += h & SIZE_MASK;
    end
    return 1'b0;
  endfunction

  // Mark a block allocated, splitting off the tail when 8 bytes or more remain.
  function automatic void carve(input int unsigned bp, input int unsigned need);
    int unsigned csize, pre, rest, nb;
    csize = hsz(bp - 4);
    pre = hrd(bp - 4) & BIT_PREV;
    if (csize >= need + 8) begin
      rest = csize - need;
      nb = bp + need;
      hwr(bp - 4, need | BIT_ALLOC | pre);
      hwr(bp + need - 8, need | BIT_ALLOC);
      hwr(nb - 4, rest | BIT_PREV);
      hwr(nb + rest - 8, rest);
    end else begin
      nb = bp + csize;
      hwr(bp - 4, csize | BIT_ALLOC | pre);
      hwr(bp + csize - 8, csize | BIT_ALLOC);
      hwr(nb - 4, hrd(nb - 4) | BIT_PREV);
    end
  endfunction

  function automatic void heap_reset();
    int unsigned bp;
    foreach (heap_img[i]) heap_img[i] = '0;
    hwr(4, 8 | BIT_ALLOC | BIT_PREV);
    hwr(8, 8 | BIT_ALLOC | BIT_PREV);
    hwr(12, BIT_ALLOC | BIT_PREV);
    brk_sh = 16;
    cursor_sh = FIRST_PAYLOAD;
    chunk_sh = CHUNK_RESET;
    void'(extend_heap(CHUNK_RESET, bp));
  endfunction

  function automatic heap_rsp_t heap_apply(input heap_req_t r);
    heap_rsp_t   o;
    int unsigned need, bp, ext, words, a, size, pre, nb, res;
    o.status = STAT_DONE;
    res = 0;
    if (r.kind == OP_ALLOC) begin
      if (r.size == 0) begin
        o.status = STAT_NULL;
      end else begin
        need = (r.size <= 8) ? 16 : 8 * ((int'(r.size) + 15) / 8);
        if (next_fit(need, bp)) begin
          carve(bp, need);
          res = bp;
        end else begin
          ext = (chunk_sh > need) ? chunk_sh : need;
          words = ext >> 2;
          if (words[0]) words++;
          if (extend_heap(words * 4, bp)) begin
            carve(bp, need);
            res = bp;
          end else begin
            o.status = STAT_OOM;
          end
        end
      end
    end else begin
      if (r.addr == 0) begin
        o.status = STAT_NULL;
      end else begin
        a = r.addr & 14'h3FFC;
        size = hsz(a - 4);
        pre = hrd(a - 4) & BIT_PREV;
        hwr(a - 4, size | pre);
        hwr(a + size - 8, size);
        nb = a + hsz(a - 4);
        hwr(nb - 4, hrd(nb - 4) & ~BIT_PREV);
        res = coalesce(a);
      end
    end
    o.addr = (o.status == STAT_DONE) ? res[13:0] : 14'd0;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Queue one request and its planned response; track live blocks.
  task automatic issue(input logic kind, input int unsigned size, input int unsigned addr,
                       output heap_rsp_t o);
    heap_req_t r;
    r.kind = kind;
    r.size = size[13:0];
    r.addr = addr[13:0];
    o = heap_apply(r);
    pending_reqs.push_back(r);
    planned_rsps.push_back(o);
    if (kind == OP_ALLOC && o.status == STAT_DONE) live_blocks.push_back(o.addr);
  endtask

  task automatic free_live(input int idx, input int unsigned low_bits);
    heap_rsp_t o;
    int unsigned a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    issue(OP_FREE, 0, a | low_bits, o);
  endtask

  function automatic int unsigned pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(64, 1);
    if (p < 95) return $urandom_range(1024, 65);
    return $urandom_range(16383, 1025);
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && planned_rsps.size() == 0 && owed_rsps.size() == 0);
    // Allow the block to settle before touching registers.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_chunk(input int unsigned v);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = REG_CHUNK;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    chunk_sh = v & 32'h7FFF;
  endtask

  // Mostly well-formed alloc/free traffic; corrupt frees only when asked.
  task automatic random_traffic(input int n, input bit wild_frees);
    heap_rsp_t o;
    int unsigned p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (wild_frees && p < 15) begin
        issue(OP_FREE, $urandom_range(16383), $urandom_range(16383), o);
      end else if (p < 3) begin
        issue(p[0] ? OP_FREE : OP_ALLOC, 0, 0, o);
      end else if (live_blocks.size() == 0 || (p < 55 && live_blocks.size() < 40)) begin
        issue(OP_ALLOC, pick_size(), $urandom_range(16383), o);
      end else begin
        free_live($urandom_range(live_blocks.size() - 1), $urandom_range(3));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: change on the falling edge, hold until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_fire <= !rst && req_ch.valid && req_ch.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fire) begin
      // hold the offered transaction
    end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      heap_req_t r;
      r = pending_reqs.pop_front();
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= r.kind;
      req_ch.req_size   <= r.size;
      req_ch.block_addr <= r.addr;
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Response readiness; a long hold-off is counted here on request.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: move plans to owed on request accept, check on response accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        if (planned_rsps.size() == 0) report("request accepted with no plan");
        else owed_rsps.push_back(planned_rsps.pop_front());
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_rsps.size() == 0) begin
          report("response with nothing owed");
        end else begin
          heap_rsp_t e;
          e = owed_rsps.pop_front();
          if (rsp_ch.status !== e.status)
            report($sformatf("status got %0d want %0d", rsp_ch.status, e.status));
          if (rsp_ch.payload_addr !== e.addr)
            report($sformatf("payload_addr got %0d want %0d", rsp_ch.payload_addr, e.addr));
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("boundary_tag_heap_allocator_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    heap_rsp_t o;
    int unsigned a, b, c;
    err_cnt = 0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    req_fire = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = OP_ALLOC;
    req_ch.req_size = '0;
    req_ch.block_addr = '0;
    rsp_ch.ready = 1'b0;
    rst = 1'b1;
    heap_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: null requests, size rounding, out of memory, three of the four merge cases.
    issue(OP_ALLOC, 0, 0, o);
    issue(OP_FREE, 0, 0, o);
    issue(OP_FREE, 0, 3, o);          // low bits only: frees address zero
    issue(OP_ALLOC, 1, 0, o);
    issue(OP_ALLOC, 8, 0, o);
    issue(OP_ALLOC, 9, 0, o);
    issue(OP_ALLOC, 16383, 14'h3FFF, o);
    issue(OP_ALLOC, 40, 0, o);  a = o.addr;
    issue(OP_ALLOC, 40, 0, o);  b = o.addr;
    issue(OP_ALLOC, 40, 0, o);  c = o.addr;
    issue(OP_ALLOC, 24, 0, o);
    live_blocks = {};
    issue(OP_FREE, 0, b | 2, o);      // both neighbors allocated
    issue(OP_FREE, 0, a, o);          // next neighbor free
    issue(OP_FREE, 0, c | 1, o);      // previous neighbor free
    issue(OP_ALLOC, 3900, 0, o);      // too large for the free space left: forces growth
    issue(OP_ALLOC, 5000, 0, o);      // forces growth
    issue(OP_ALLOC, 16, 0, o);
    issue(OP_ALLOC, 8000, 0, o);      // no room left to grow
    drain();

    // Pressure: stall responses for a long stretch while requests keep coming.
    hold_asks++;
    random_traffic(200, 1'b0);
    drain();

    write_chunk(16);
    send_idle_pct = 55;
    recv_stall_pct = 0;
    random_traffic(200, 1'b0);
    drain();

    write_chunk(16384);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    random_traffic(200, 1'b0);
    drain();

    write_chunk($urandom_range(16384, 16));
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_traffic(200, 1'b0);
    drain();

    // Last: stray frees on whatever words are there.
    write_chunk(CHUNK_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_traffic(60, 1'b1);
    drain();
    repeat (60) @(posedge clk);

    if (err_cnt == 0) begin
      $display("boundary_tag_heap_allocator_unit_tb: clean");
    end else begin
      $display("boundary_tag_heap_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* boundary_tag_heap_allocator_unit.f */
rtl/core/bthal_pkg.sv
rtl/core/bthal_if.sv
rtl/core/bthal_ram.sv
rtl/core/boundary_tag_heap_allocator_unit.sv
rtl/core/bthal_checker.sv
sim/boundary_tag_heap_allocator_unit_tb.sv
